### rtl/xyrc_pkg.sv
// Shared types, constants and helpers for the XY route channel load counter.
package xyrc_pkg;

  localparam int MAX_SIDE_DEF    = 8;
  localparam int MAX_HOSTS_DEF   = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TORUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOSTS = 2'd2;

  localparam logic [3:0] SIDE_RST  = 4'd4;
  localparam logic       TORUS_RST = 1'b0;
  localparam logic [2:0] HOSTS_RST = 3'd1;

  localparam logic OP_ROUTE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int SLOT_XP      = 1;
  localparam int SLOT_XN      = 2;
  localparam int SLOT_YP      = 3;
  localparam int SLOT_YN      = 4;
  localparam int SLOT_LOCAL   = 5;
  localparam int NUM_VC_TORUS = 2;

  localparam int CHAN_W  = 11;
  localparam int FLOW_W  = 16;
  localparam int HOST_W  = 8;

  typedef struct packed {
    logic              operation;
    logic [HOST_W-1:0] source_host;
    logic [HOST_W-1:0] dest_host;
    logic [CHAN_W-1:0] query_channel;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_index;
    logic [FLOW_W-1:0] flow_count;
    logic              last;
    logic              error;
  } out_item_t;

  // quotient of a host number by a small host count, reciprocal multiply for odd divisors
  function automatic logic [HOST_W-1:0] div_small(input logic [HOST_W-1:0] x,
                                                  input logic [3:0] d);
    logic [18:0]       p;
    logic [HOST_W-1:0] q;
    p = '0;
    q = x;
    case (d)
      4'd1: q = x;
      4'd2: q = x >> 1;
      4'd3: begin
        p = 19'(x) * 19'd171;
        q = p[16:9];
      end
      4'd4: q = x >> 2;
      4'd5: begin
        p = 19'(x) * 19'd205;
        q = p[17:10];
      end
      4'd6: begin
        p = 19'(x >> 1) * 19'd171;
        q = p[16:9];
      end
      4'd7: begin
        p = 19'(x) * 19'd293;
        q = p[18:11];
      end
      4'd8: q = x >> 3;
      default: q = x;
    endcase
    return q;
  endfunction

endpackage

### rtl/xy_route_channel_load_counter_core.sv
// XY route walker with per-channel saturating flow counters held in one memory.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data             | route or read request item
//  out     | out_valid, out_ready, out_data          | one result item per channel
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register write, no wait
//
// A read item passes through the request register, the issue stage and the result register;
// the next item is taken once the issue stage is empty. A route item is set up, its router
// numbers are split into coordinates, and then its channels (injection, links, ejection; up
// to 16) go one by one through the counter read-modify-write port; the next item is taken
// once the last channel has left the issue stage. After reset a clearing pass zeroes the
// MAX_SIDE*MAX_SIDE*2*(5+2*MAX_HOSTS) counters (1664 by default); no item is accepted
// meanwhile. A stalled output holds the result register and the walk waits on it.
module xy_route_channel_load_counter_core #(
  parameter int MAX_SIDE    = xyrc_pkg::MAX_SIDE_DEF,
  parameter int MAX_HOSTS   = xyrc_pkg::MAX_HOSTS_DEF,
  parameter int COUNT_WIDTH = xyrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  xyrc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output xyrc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [xyrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xyrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SLOTS_MAX = xyrc_pkg::SLOT_LOCAL + 2 * MAX_HOSTS;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE * xyrc_pkg::NUM_VC_TORUS * SLOTS_MAX;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int R_W       = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int HPR_W     = $clog2(MAX_HOSTS + 1);
  localparam int SLOT_W    = $clog2(SLOTS_MAX + 1);
  localparam int STRIDE_W  = $clog2(xyrc_pkg::NUM_VC_TORUS * SLOTS_MAX + 1);
  localparam int TH_W      = $clog2(MAX_SIDE * MAX_SIDE * MAX_HOSTS + 1);
  localparam int TC_W      = $clog2(DEPTH + 1);
  localparam int CW        = ((R_W > SIDE_W) ? R_W : SIDE_W) + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_COORD = 3'd3;
  localparam logic [2:0] ST_HOP   = 3'd4;

  localparam logic [1:0] HK_INJ = 2'd0;
  localparam logic [1:0] HK_X   = 2'd1;
  localparam logic [1:0] HK_Y   = 2'd2;
  localparam logic [1:0] HK_EJ  = 2'd3;

  // configuration
  logic [3:0] side_r;
  logic       torus_r;
  logic [2:0] hpr_r;

  logic [SIDE_W-1:0]   side_sat;
  logic [HPR_W-1:0]    hpr_sat;
  logic [SLOT_W-1:0]   slots;
  logic [STRIDE_W-1:0] stride;
  logic [TH_W-1:0]     total_hosts;
  logic [TC_W-1:0]     total_ch;
  logic [R_W-1:0]      side_r_w;
  logic [R_W-1:0]      sm1s;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [1:0]        hop_r, hop_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  xyrc_pkg::in_item_t  item_r, item_nxt;
  xyrc_pkg::out_item_t out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]   p_addr_r, p_addr_nxt;
  logic [xyrc_pkg::CHAN_W-1:0] p_idx_r, p_idx_nxt;
  logic                p_last_r, p_last_nxt;
  logic                p_err_r, p_err_nxt;
  logic                p_rd_r, p_rd_nxt;
  logic                p_wr_r, p_wr_nxt;

  logic [R_W-1:0]    s_rem_r, s_rem_nxt, d_rem_r, d_rem_nxt;
  logic [SIDE_W-1:0] s_y_r, s_y_nxt, d_y_r, d_y_nxt;
  logic [R_W-1:0]    cur_r, cur_nxt;
  logic [SIDE_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [SIDE_W-1:0] x_cnt_r, x_cnt_nxt, y_cnt_r, y_cnt_nxt;
  logic              x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic              wx_r, wx_nxt, wy_r, wy_nxt;
  logic [HPR_W-1:0]  k_s_r, k_s_nxt, k_d_r, k_d_nxt;
  logic              vc_inj_r, vc_inj_nxt, vc_ej_r, vc_ej_nxt;

  // counter memory
  logic [COUNT_WIDTH-1:0] cnt_mem_r [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_rdata_r;
  logic                   mem_re, mem_we;
  logic [ADDR_W-1:0]      mem_raddr, mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // combinational helpers
  logic                   out_free, can_issue;
  logic [COUNT_WIDTH-1:0] cnt_inc, p_value;
  logic [xyrc_pkg::HOST_W-1:0] s_q, d_q, s_prod, d_prod;
  logic                   host_bad, q_ok;
  logic                   s_more, d_more;
  logic [SIDE_W-1:0]      sxc, dxc;
  logic signed [SIDE_W:0] dx_s, dy_s;
  logic [SIDE_W-1:0]      dx_mag, dy_mag;
  logic                   dx_neg, dy_neg, dx_wrap, dy_wrap;
  logic [SLOT_W-1:0]      hop_slot;
  logic                   hop_vc;
  logic [ADDR_W-1:0]      hop_addr;
  logic                   iss, iss_last, iss_err, iss_rd, iss_wr;
  logic [ADDR_W-1:0]      iss_addr;
  logic [xyrc_pkg::CHAN_W-1:0] iss_idx;
  logic [1:0]             after_x;

  // saturated configuration and derived layout
  always_comb begin
    if (side_r < 4'd2) begin
      side_sat = SIDE_W'(2);
    end else if (int'(side_r) > MAX_SIDE) begin
      side_sat = SIDE_W'(MAX_SIDE);
    end else begin
      side_sat = SIDE_W'(side_r);
    end
    if (hpr_r == 3'd0) begin
      hpr_sat = HPR_W'(1);
    end else if (int'(hpr_r) > MAX_HOSTS) begin
      hpr_sat = HPR_W'(MAX_HOSTS);
    end else begin
      hpr_sat = HPR_W'(hpr_r);
    end
  end

  assign slots       = SLOT_W'(xyrc_pkg::SLOT_LOCAL) + SLOT_W'({hpr_sat, 1'b0});
  assign stride      = torus_r ? STRIDE_W'({slots, 1'b0}) : STRIDE_W'(slots);
  assign total_hosts = TH_W'(side_sat) * TH_W'(side_sat) * TH_W'(hpr_sat);
  assign total_ch    = TC_W'(side_sat) * TC_W'(side_sat) * TC_W'(stride);
  assign side_r_w    = R_W'(side_sat);
  assign sm1s        = R_W'(side_r_w * (side_r_w - R_W'(1)));

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign can_issue = !p_valid_r || out_free;
  assign in_ready  = (state_r == ST_IDLE) && !p_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // data stage value
  assign cnt_inc = (mem_rdata_r == {COUNT_WIDTH{1'b1}}) ? mem_rdata_r
                                                        : mem_rdata_r + COUNT_WIDTH'(1);
  always_comb begin
    if (p_err_r || !p_rd_r) begin
      p_value = '0;
    end else if (p_wr_r) begin
      p_value = cnt_inc;
    end else begin
      p_value = mem_rdata_r;
    end
  end

  // request set-up
  assign s_q      = xyrc_pkg::div_small(item_r.source_host, 4'(hpr_sat));
  assign d_q      = xyrc_pkg::div_small(item_r.dest_host, 4'(hpr_sat));
  assign s_prod   = xyrc_pkg::HOST_W'(s_q * xyrc_pkg::HOST_W'(hpr_sat));
  assign d_prod   = xyrc_pkg::HOST_W'(d_q * xyrc_pkg::HOST_W'(hpr_sat));
  assign host_bad = (TH_W'(item_r.source_host) >= total_hosts) ||
                    (TH_W'(item_r.dest_host) >= total_hosts) ||
                    (int'(item_r.source_host) >= int'(total_hosts)) ||
                    (int'(item_r.dest_host) >= int'(total_hosts));
  assign q_ok     = (int'(item_r.query_channel) < int'(total_ch)) &&
                    (int'(item_r.query_channel) < DEPTH);

  // coordinates and torus shortcut
  assign s_more = CW'(s_rem_r) >= CW'(side_sat);
  assign d_more = CW'(d_rem_r) >= CW'(side_sat);
  assign sxc    = SIDE_W'(s_rem_r);
  assign dxc    = SIDE_W'(d_rem_r);

  always_comb begin
    dx_s    = $signed({1'b0, dxc}) - $signed({1'b0, sxc});
    dy_s    = $signed({1'b0, d_y_r}) - $signed({1'b0, s_y_r});
    dx_neg  = dx_s[SIDE_W];
    dy_neg  = dy_s[SIDE_W];
    dx_mag  = dx_neg ? SIDE_W'(-dx_s) : SIDE_W'(dx_s);
    dy_mag  = dy_neg ? SIDE_W'(-dy_s) : SIDE_W'(dy_s);
    dx_wrap = torus_r && (dx_mag > (side_sat >> 1));
    dy_wrap = torus_r && (dy_mag > (side_sat >> 1));
    if (dx_wrap) begin
      dx_neg = !dx_neg;
      dx_mag = side_sat - dx_mag;
    end
    if (dy_wrap) begin
      dy_neg = !dy_neg;
      dy_mag = side_sat - dy_mag;
    end
  end

  // channel of the current hop
  always_comb begin
    case (hop_r)
      HK_INJ: begin
        hop_slot = SLOT_W'(xyrc_pkg::SLOT_LOCAL) + SLOT_W'(k_s_r);
        hop_vc   = vc_inj_r;
      end
      HK_X: begin
        hop_slot = x_neg_r ? SLOT_W'(xyrc_pkg::SLOT_XN) : SLOT_W'(xyrc_pkg::SLOT_XP);
        hop_vc   = wx_r;
      end
      HK_Y: begin
        hop_slot = y_neg_r ? SLOT_W'(xyrc_pkg::SLOT_YN) : SLOT_W'(xyrc_pkg::SLOT_YP);
        hop_vc   = wy_r;
      end
      HK_EJ: begin
        hop_slot = SLOT_W'(xyrc_pkg::SLOT_LOCAL) + SLOT_W'(hpr_sat) + SLOT_W'(k_d_r);
        hop_vc   = vc_ej_r;
      end
      default: begin
        hop_slot = '0;
        hop_vc   = 1'b0;
      end
    endcase
    hop_addr = ADDR_W'(ADDR_W'(cur_r) * ADDR_W'(stride)) +
               (hop_vc ? ADDR_W'(slots) : ADDR_W'(0)) + ADDR_W'(hop_slot);
  end

  assign after_x = (y_cnt_r != '0) ? HK_Y : HK_EJ;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    hop_nxt     = hop_r;
    item_nxt    = item_r;
    s_rem_nxt   = s_rem_r;
    d_rem_nxt   = d_rem_r;
    s_y_nxt     = s_y_r;
    d_y_nxt     = d_y_r;
    cur_nxt     = cur_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    x_cnt_nxt   = x_cnt_r;
    y_cnt_nxt   = y_cnt_r;
    x_neg_nxt   = x_neg_r;
    y_neg_nxt   = y_neg_r;
    wx_nxt      = wx_r;
    wy_nxt      = wy_r;
    k_s_nxt     = k_s_r;
    k_d_nxt     = k_d_r;
    vc_inj_nxt  = vc_inj_r;
    vc_ej_nxt   = vc_ej_r;
    iss         = 1'b0;
    iss_addr    = '0;
    iss_idx     = '0;
    iss_last    = 1'b0;
    iss_err     = 1'b0;
    iss_rd      = 1'b0;
    iss_wr      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt  = in_data;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (item_r.operation == xyrc_pkg::OP_READ) begin
          iss       = 1'b1;
          iss_addr  = ADDR_W'(item_r.query_channel);
          iss_idx   = item_r.query_channel;
          iss_last  = 1'b1;
          iss_err   = !q_ok;
          iss_rd    = q_ok;
          state_nxt = ST_IDLE;
        end else if (host_bad) begin
          iss       = 1'b1;
          iss_last  = 1'b1;
          iss_err   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          s_rem_nxt  = R_W'(s_q);
          d_rem_nxt  = R_W'(d_q);
          s_y_nxt    = '0;
          d_y_nxt    = '0;
          cur_nxt    = R_W'(s_q);
          k_s_nxt    = HPR_W'(item_r.source_host - s_prod);
          k_d_nxt    = HPR_W'(item_r.dest_host - d_prod);
          vc_inj_nxt = torus_r && d_q[0];
          vc_ej_nxt  = torus_r && s_q[0];
          state_nxt  = ST_COORD;
        end
      end
      ST_COORD: begin
        if (s_more || d_more) begin
          if (s_more) begin
            s_rem_nxt = s_rem_r - side_r_w;
            s_y_nxt   = s_y_r + SIDE_W'(1);
          end
          if (d_more) begin
            d_rem_nxt = d_rem_r - side_r_w;
            d_y_nxt   = d_y_r + SIDE_W'(1);
          end
        end else begin
          cur_x_nxt = sxc;
          cur_y_nxt = s_y_r;
          x_cnt_nxt = dx_mag;
          y_cnt_nxt = dy_mag;
          x_neg_nxt = dx_neg;
          y_neg_nxt = dy_neg;
          wx_nxt    = dx_wrap;
          wy_nxt    = dy_wrap;
          hop_nxt   = HK_INJ;
          state_nxt = ST_HOP;
        end
      end
      ST_HOP: begin
        if (can_issue) begin
          iss      = 1'b1;
          iss_addr = hop_addr;
          iss_idx  = xyrc_pkg::CHAN_W'(hop_addr);
          iss_rd   = 1'b1;
          iss_wr   = 1'b1;
          case (hop_r)
            HK_INJ: begin
              hop_nxt = (x_cnt_r != '0) ? HK_X : after_x;
            end
            HK_X: begin
              x_cnt_nxt = x_cnt_r - SIDE_W'(1);
              hop_nxt   = (x_cnt_r != SIDE_W'(1)) ? HK_X : after_x;
              if (!x_neg_r) begin
                if (cur_x_r == side_sat - SIDE_W'(1)) begin
                  wx_nxt    = 1'b0;
                  cur_nxt   = cur_r - (side_r_w - R_W'(1));
                  cur_x_nxt = '0;
                end else begin
                  cur_nxt   = cur_r + R_W'(1);
                  cur_x_nxt = cur_x_r + SIDE_W'(1);
                end
              end else begin
                if (cur_x_r == '0) begin
                  wx_nxt    = 1'b0;
                  cur_nxt   = cur_r + (side_r_w - R_W'(1));
                  cur_x_nxt = side_sat - SIDE_W'(1);
                end else begin
                  cur_nxt   = cur_r - R_W'(1);
                  cur_x_nxt = cur_x_r - SIDE_W'(1);
                end
              end
            end
            HK_Y: begin
              y_cnt_nxt = y_cnt_r - SIDE_W'(1);
              hop_nxt   = (y_cnt_r != SIDE_W'(1)) ? HK_Y : HK_EJ;
              if (!y_neg_r) begin
                if (cur_y_r == side_sat - SIDE_W'(1)) begin
                  wy_nxt    = 1'b0;
                  cur_nxt   = cur_r - sm1s;
                  cur_y_nxt = '0;
                end else begin
                  cur_nxt   = cur_r + side_r_w;
                  cur_y_nxt = cur_y_r + SIDE_W'(1);
                end
              end else begin
                if (cur_y_r == '0) begin
                  wy_nxt    = 1'b0;
                  cur_nxt   = cur_r + sm1s;
                  cur_y_nxt = side_sat - SIDE_W'(1);
                end else begin
                  cur_nxt   = cur_r - side_r_w;
                  cur_y_nxt = cur_y_r - SIDE_W'(1);
                end
              end
            end
            HK_EJ: begin
              iss_last  = 1'b1;
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // data stage: write back and hand to the output register
    if (p_valid_r && out_free && p_wr_r && !p_err_r) begin
      mem_we    = 1'b1;
      mem_waddr = p_addr_r;
      mem_wdata = cnt_inc;
    end
  end

  assign mem_re    = iss && iss_rd;
  assign mem_raddr = iss_addr;

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_addr_nxt  = p_addr_r;
    p_idx_nxt   = p_idx_r;
    p_last_nxt  = p_last_r;
    p_err_nxt   = p_err_r;
    p_rd_nxt    = p_rd_r;
    p_wr_nxt    = p_wr_r;
    if (iss) begin
      p_valid_nxt = 1'b1;
      p_addr_nxt  = iss_addr;
      p_idx_nxt   = iss_idx;
      p_last_nxt  = iss_last;
      p_err_nxt   = iss_err;
      p_rd_nxt    = iss_rd;
      p_wr_nxt    = iss_wr;
    end else if (p_valid_r && out_free) begin
      p_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (p_valid_r && out_free) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.channel_index = p_idx_r;
      out_data_nxt.flow_count    = xyrc_pkg::FLOW_W'(p_value);
      out_data_nxt.last          = p_last_r;
      out_data_nxt.error         = p_err_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= cnt_mem_r[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hop_r       <= HK_INJ;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      side_r      <= xyrc_pkg::SIDE_RST;
      torus_r     <= xyrc_pkg::TORUS_RST;
      hpr_r       <= xyrc_pkg::HOSTS_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hop_r       <= hop_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          xyrc_pkg::CFG_SIDE:  side_r  <= cfg_wdata[3:0];
          xyrc_pkg::CFG_TORUS: torus_r <= cfg_wdata[0];
          xyrc_pkg::CFG_HOSTS: hpr_r   <= cfg_wdata[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    p_addr_r   <= p_addr_nxt;
    p_idx_r    <= p_idx_nxt;
    p_last_r   <= p_last_nxt;
    p_err_r    <= p_err_nxt;
    p_rd_r     <= p_rd_nxt;
    p_wr_r     <= p_wr_nxt;
    s_rem_r    <= s_rem_nxt;
    d_rem_r    <= d_rem_nxt;
    s_y_r      <= s_y_nxt;
    d_y_r      <= d_y_nxt;
    cur_r      <= cur_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    x_cnt_r    <= x_cnt_nxt;
    y_cnt_r    <= y_cnt_nxt;
    x_neg_r    <= x_neg_nxt;
    y_neg_r    <= y_neg_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    k_s_r      <= k_s_nxt;
    k_d_r      <= k_d_nxt;
    vc_inj_r   <= vc_inj_nxt;
    vc_ej_r    <= vc_ej_nxt;
  end

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!p_valid_r && !in_ready))
    else $error("item in flight during counter clearing");

  a_x_hop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOP && hop_r == HK_X) |-> (x_cnt_r != '0))
    else $error("X hop issued with no X distance left");

  a_y_hop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOP && hop_r == HK_Y) |-> (y_cnt_r != '0))
    else $error("Y hop issued with no Y distance left");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is at work");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && p_err_r) |-> (p_last_r && !p_rd_r))
    else $error("error result not final or reads memory");
`endif

endmodule
